// File: hw/rtl/ctd_pkg.sv
`timescale 1ns / 1ps

package ctd_pkg;

    localparam int unsigned DIGIT_BITS = 4;

    localparam logic [7:0] CHR_CR   = 8'h0D;
    localparam logic [7:0] CHR_LF   = 8'h0A;
    localparam logic [7:0] CHR_SEMI = 8'h3B;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_SIZE_CR = 3'd1,
        PH_EXT     = 3'd2,
        PH_EXT_CR  = 3'd3,
        PH_DATA    = 3'd4,
        PH_END_CR  = 3'd5,
        PH_END_LF  = 3'd6,
        PH_DONE    = 3'd7
    } t_phase;

    typedef enum logic [2:0] {
        ST_RUN   = 3'd0,
        ST_DONE  = 3'd1,
        ST_HDR   = 3'd2,
        ST_SIZE  = 3'd3,
        ST_TRUNC = 3'd4,
        ST_END   = 3'd5
    } t_status;

    typedef struct packed {
        logic                  ok;
        logic [DIGIT_BITS-1:0] val;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] b);
        t_hex h;
        h.ok  = 1'b1;
        h.val = '0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.val = 4'(b - 8'h30);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.val = 4'(b - 8'h57);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.val = 4'(b - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

endpackage

// File: hw/rtl/chunked_transfer_decoder.sv
`timescale 1ns / 1ps
// Streaming decoder for an HTTP chunked body.
// Input channel: one raw body byte per beat on i_in_byte, with i_in_last set on
// the final byte of a body. A beat is taken when i_valid is high and o_stall is
// low. Output channel: exactly one result beat per input beat, carrying the
// payload byte (o_out_byte, o_out_valid) and the decode status (o_status),
// taken when o_valid is high and i_stall is low.
// The result register is the only stage between the sides, so a result beat
// is offered in the cycle after its input beat is taken; the block takes one
// beat every cycle unless the receiver stalls; then the held result stays and
// o_stall rises, so no new beat is taken until the result has been taken.
// Payload bytes are passed on as they arrive; if a later error is reported,
// the consumer discards what it received for that body.
// After i_in_last the decoder returns to its reset state for the next body.
// Reset (synchronous, active low) empties the result register and returns
// the parser to the start of a size line.
module chunked_transfer_decoder #(
    parameter int unsigned SIZE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic [2:0] o_status
);
    import ctd_pkg::*;

    t_phase                r_phase;
    t_phase                n_phase;
    logic [SIZE_BITS-1:0]  r_bytes_left;
    logic [SIZE_BITS-1:0]  n_bytes_left;
    logic [3:0]            r_digit_count;
    logic [3:0]            n_digit_count;
    logic                  r_size_bad;
    logic                  n_size_bad;
    logic                  r_end_bad;
    logic                  n_end_bad;
    t_status               r_final;
    t_status               n_final;

    logic                  r_valid;
    logic [7:0]            r_out_byte;
    logic                  r_out_valid;
    t_status               r_status;

    t_phase                c_phase;
    logic [SIZE_BITS-1:0]  c_bytes;
    logic [3:0]            c_digits;
    logic                  c_sbad;
    logic                  c_ebad;
    t_status               c_st;
    logic                  c_line_done;
    logic                  c_valid;
    t_status               c_status;
    logic [7:0]            c_byte;
    t_hex                  w_hex;
    logic                  w_in_acc;

    assign w_hex    = hex_decode(i_in_byte);
    assign o_stall  = r_valid && i_stall;
    assign w_in_acc = i_valid && !o_stall;

    always_comb begin
        c_phase     = r_phase;
        c_bytes     = r_bytes_left;
        c_digits    = r_digit_count;
        c_sbad      = r_size_bad;
        c_ebad      = r_end_bad;
        c_st        = ST_RUN;
        c_line_done = 1'b0;
        c_valid     = 1'b0;
        case (r_phase)
            PH_SIZE: begin
                if (i_in_byte == CHR_CR) begin
                    c_phase = PH_SIZE_CR;
                end else if (i_in_byte == CHR_SEMI) begin
                    c_phase = PH_EXT;
                end else if (!w_hex.ok) begin
                    c_sbad = 1'b1;
                end else begin
                    if (r_bytes_left[SIZE_BITS-1 -: DIGIT_BITS] != '0) begin
                        c_sbad = 1'b1;
                    end else begin
                        c_bytes = {r_bytes_left[SIZE_BITS-DIGIT_BITS-1:0], w_hex.val};
                    end
                    if (r_digit_count != 4'hF) begin
                        c_digits = r_digit_count + 4'd1;
                    end
                end
            end
            PH_SIZE_CR, PH_EXT_CR: begin
                if (i_in_byte == CHR_LF) begin
                    c_line_done = 1'b1;
                    if (r_size_bad || r_digit_count == 4'd0) begin
                        c_st = ST_SIZE;
                    end else if (r_bytes_left == '0) begin
                        c_st = ST_DONE;
                    end else begin
                        c_phase = PH_DATA;
                    end
                end else if (r_phase == PH_SIZE_CR) begin
                    c_sbad = 1'b1;
                    if (i_in_byte == CHR_SEMI) begin
                        c_phase = PH_EXT;
                    end else if (i_in_byte != CHR_CR) begin
                        c_phase = PH_SIZE;
                    end
                end else if (i_in_byte != CHR_CR) begin
                    c_phase = PH_EXT;
                end
            end
            PH_EXT: begin
                if (i_in_byte == CHR_CR) begin
                    c_phase = PH_EXT_CR;
                end
            end
            PH_DATA: begin
                c_valid = 1'b1;
                if (r_bytes_left != '0) begin
                    c_bytes = r_bytes_left - SIZE_BITS'(1);
                end
                if (r_bytes_left <= SIZE_BITS'(1)) begin
                    c_phase = PH_END_CR;
                end
                if (i_in_last) begin
                    c_st = ST_TRUNC;
                end
            end
            PH_END_CR: begin
                if (i_in_byte != CHR_CR) begin
                    c_ebad = 1'b1;
                end
                c_phase = PH_END_LF;
                if (i_in_last) begin
                    c_st = ST_TRUNC;
                end
            end
            PH_END_LF: begin
                if (i_in_byte != CHR_LF || r_end_bad) begin
                    c_st = ST_END;
                end else begin
                    c_phase  = PH_SIZE;
                    c_bytes  = '0;
                    c_digits = '0;
                    c_sbad   = 1'b0;
                    c_ebad   = 1'b0;
                    if (i_in_last) begin
                        c_st = ST_HDR;
                    end
                end
            end
            default: begin
                c_st = r_final;
            end
        endcase
    end

    always_comb begin
        c_status = c_st;
        if (i_in_last && c_st == ST_RUN) begin
            if (c_line_done) begin
                c_status = ST_TRUNC;
            end else if (c_phase == PH_SIZE || c_phase == PH_SIZE_CR ||
                         c_phase == PH_EXT || c_phase == PH_EXT_CR) begin
                c_status = ST_HDR;
            end
        end
        c_byte = c_valid ? i_in_byte : 8'h00;
    end

    always_comb begin
        n_phase       = c_phase;
        n_bytes_left  = c_bytes;
        n_digit_count = c_digits;
        n_size_bad    = c_sbad;
        n_end_bad     = c_ebad;
        n_final       = r_final;
        if (i_in_last) begin
            n_phase       = PH_SIZE;
            n_bytes_left  = '0;
            n_digit_count = '0;
            n_size_bad    = 1'b0;
            n_end_bad     = 1'b0;
            n_final       = ST_RUN;
        end else if (c_status != ST_RUN) begin
            n_phase = PH_DONE;
            n_final = c_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_SIZE;
            r_bytes_left  <= '0;
            r_digit_count <= '0;
            r_size_bad    <= 1'b0;
            r_end_bad     <= 1'b0;
            r_final       <= ST_RUN;
        end else if (w_in_acc) begin
            r_phase       <= n_phase;
            r_bytes_left  <= n_bytes_left;
            r_digit_count <= n_digit_count;
            r_size_bad    <= n_size_bad;
            r_end_bad     <= n_end_bad;
            r_final       <= n_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out_byte  <= c_byte;
            r_out_valid <= c_valid;
            r_status    <= c_status;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;

endmodule

// File: hw/rtl/ctd_checker.sv
`timescale 1ns / 1ps

module ctd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_out_valid,
    input logic [2:0] o_status
);
    import ctd_pkg::*;

    // A stalled result beat stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result beat dropped while stalled");

    // A full, stalled result register must hold off the input side.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("input taken while result is stalled");

    // A payload byte is only reported while running or on truncation.
    a_payload_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_valid |-> (o_status == ST_RUN || o_status == ST_TRUNC))
        else $error("payload byte with a final status");

    // Non-payload results carry a zero byte.
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_valid |-> o_out_byte == 8'h00)
        else $error("non-payload result with nonzero byte");

    // The result register is empty after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind chunked_transfer_decoder ctd_checker u_ctd_checker (.*);
